// File: rtl/core/sshp_pkg.sv
// ----------------------------------------------------------------------------
// sshp_pkg
// Shared types and constants of the SPI slave command header parser.
// ----------------------------------------------------------------------------
package sshp_pkg;

	localparam logic [7:0]  LETTER_LOW_BOUND  = 8'h40;
	localparam logic [7:0]  LETTER_HIGH_BOUND = 8'h5B;

	localparam logic [7:0]  WRITE_OPCODE_RST = 8'h01;
	localparam logic [7:0]  READ_OPCODE_RST  = 8'h02;
	localparam logic [7:0]  DUMMY_VALUE_RST  = 8'hFF;
	localparam logic [15:0] MAX_LENGTH_RST   = 16'd2048;

	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_PTR_W = 1;
	localparam int unsigned Q_CNT_W = 2;

	typedef enum logic [1:0] {
		REG_WRITE_OPCODE = 2'd0,
		REG_READ_OPCODE  = 2'd1,
		REG_DUMMY_VALUE  = 2'd2,
		REG_MAX_LENGTH   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_AT    = 2'd2,
		KIND_NACK  = 2'd3
	} frame_kind_t;

	typedef enum logic [4:0] {
		PH_COMMAND = 5'b00001,
		PH_LENGTH  = 5'b00010,
		PH_DUMMY   = 5'b00100,
		PH_ATCMD   = 5'b01000,
		PH_HOLD    = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [7:0]  write_opcode;
		logic [7:0]  read_opcode;
		logic [7:0]  dummy_value;
		logic [15:0] max_length;
	} cfg_t;

	// classified word handed from front to back
	typedef struct packed {
		logic       release_req;
		logic [7:0] rx_byte;
		logic       store_permitted;
		logic       is_write_op;
		logic       is_read_op;
		logic       is_letter;
		logic       dummy_ok;
	} item_t;

endpackage

// File: rtl/core/sshp_if.sv
// ----------------------------------------------------------------------------
// sshp_if
// Valid/ready channels of the header parser: received words and results.
// ----------------------------------------------------------------------------
interface sshp_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] rx_byte;
	logic       store_permitted;

	modport source (output valid, cmd, rx_byte, store_permitted, input ready);
	modport sink   (input valid, cmd, rx_byte, store_permitted, output ready);
endinterface

interface sshp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  frame_kind;
	logic [15:0] frame_length;
	logic [31:0] atcmd_word;

	modport source (output valid, frame_kind, frame_length, atcmd_word, input ready);
	modport sink   (input valid, frame_kind, frame_length, atcmd_word, output ready);
endinterface

// File: rtl/core/sshp_front.sv
// ----------------------------------------------------------------------------
// sshp_front
// Accepts input words and classifies the byte against the configured codes.
// ----------------------------------------------------------------------------
module sshp_front (
	sshp_in_if.sink        req,
	input  sshp_pkg::cfg_t cfg,
	input  logic           q_full,
	output logic           push,
	output sshp_pkg::item_t item
);

	assign req.ready = !q_full;
	assign push      = req.valid && !q_full;

	always_comb begin
		item.release_req     = req.cmd;
		item.rx_byte         = req.rx_byte;
		item.store_permitted = req.store_permitted;
		item.is_write_op     = (req.rx_byte == cfg.write_opcode);
		item.is_read_op      = (req.rx_byte == cfg.read_opcode);
		item.is_letter       = (req.rx_byte > sshp_pkg::LETTER_LOW_BOUND) &&
		                       (req.rx_byte < sshp_pkg::LETTER_HIGH_BOUND);
		item.dummy_ok        = (req.rx_byte == cfg.dummy_value);
	end

endmodule

// File: rtl/core/sshp_queue.sv
// ----------------------------------------------------------------------------
// sshp_queue
// Two-entry queue of classified words between front and back.
// ----------------------------------------------------------------------------
module sshp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sshp_pkg::item_t push_item,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output sshp_pkg::item_t head
);

	sshp_pkg::item_t                 mem_q [sshp_pkg::Q_DEPTH];
	logic [sshp_pkg::Q_PTR_W-1:0]    wr_ptr_q;
	logic [sshp_pkg::Q_PTR_W-1:0]    rd_ptr_q;
	logic [sshp_pkg::Q_CNT_W-1:0]    count_q;

	assign full      = (count_q == sshp_pkg::Q_CNT_W'(sshp_pkg::Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

endmodule

// File: rtl/core/sshp_back.sv
// ----------------------------------------------------------------------------
// sshp_back
// Header state machine: walks the frame phases and drives the result register.
// ----------------------------------------------------------------------------
module sshp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [15:0]     max_length,
	input  logic            q_not_empty,
	input  sshp_pkg::item_t head,
	output logic            pop,
	sshp_out_if.source      rsp
);

	sshp_pkg::phase_t      phase_q, phase_d;
	sshp_pkg::frame_kind_t req_kind_q, req_kind_d;
	logic [1:0]            byte_cnt_q, byte_cnt_d;
	logic [1:0]            dummy_cnt_q, dummy_cnt_d;
	logic [1:0]            dummy_inc;
	logic [7:0]            len_low_q;
	logic [15:0]           decl_len_q;
	logic [15:0]           len_new;
	logic [7:0]            at_q [4];
	logic                  len_low_we, decl_len_we, at_we;
	logic [1:0]            at_idx;

	logic                  emit;
	sshp_pkg::frame_kind_t emit_kind;
	logic [15:0]           emit_len;
	logic [31:0]           emit_word;

	logic                  out_valid_q;
	logic [1:0]            out_kind_q;
	logic [15:0]           out_len_q;
	logic [31:0]           out_word_q;

	assign pop       = q_not_empty && (!out_valid_q || rsp.ready);
	assign len_new   = {head.rx_byte, len_low_q};
	assign dummy_inc = dummy_cnt_q + 2'd1;

	always_comb begin
		phase_d     = phase_q;
		req_kind_d  = req_kind_q;
		byte_cnt_d  = byte_cnt_q;
		dummy_cnt_d = dummy_cnt_q;
		len_low_we  = 1'b0;
		decl_len_we = 1'b0;
		at_we       = 1'b0;
		at_idx      = byte_cnt_q;
		emit        = 1'b0;
		emit_kind   = sshp_pkg::KIND_NACK;
		emit_len    = '0;
		emit_word   = '0;
		if (head.release_req) begin
			phase_d     = sshp_pkg::PH_COMMAND;
			byte_cnt_d  = '0;
			dummy_cnt_d = '0;
		end else begin
			unique case (phase_q)
				sshp_pkg::PH_COMMAND: begin
					if (head.is_write_op) begin
						req_kind_d = sshp_pkg::KIND_WRITE;
						if (!head.store_permitted) begin
							emit = 1'b1;
						end else begin
							byte_cnt_d = '0;
							phase_d    = sshp_pkg::PH_LENGTH;
						end
					end else if (head.is_read_op) begin
						req_kind_d  = sshp_pkg::KIND_READ;
						dummy_cnt_d = '0;
						phase_d     = sshp_pkg::PH_DUMMY;
					end else if (head.is_letter) begin
						req_kind_d = sshp_pkg::KIND_AT;
						at_we      = 1'b1;
						at_idx     = 2'd0;
						byte_cnt_d = 2'd1;
						phase_d    = sshp_pkg::PH_ATCMD;
					end
				end
				sshp_pkg::PH_LENGTH: begin
					if (byte_cnt_q == 2'd0) begin
						len_low_we = 1'b1;
						byte_cnt_d = 2'd1;
					end else begin
						byte_cnt_d  = '0;
						decl_len_we = 1'b1;
						if (len_new > max_length) begin
							emit = 1'b1;
						end else begin
							dummy_cnt_d = '0;
							phase_d     = sshp_pkg::PH_DUMMY;
						end
					end
				end
				sshp_pkg::PH_DUMMY: begin
					if (!head.dummy_ok) begin
						dummy_cnt_d = '0;
						emit        = 1'b1;
					end else if (req_kind_q == sshp_pkg::KIND_WRITE && dummy_inc == 2'd1) begin
						dummy_cnt_d = '0;
						emit        = 1'b1;
						emit_kind   = sshp_pkg::KIND_WRITE;
						emit_len    = decl_len_q;
					end else if (req_kind_q == sshp_pkg::KIND_READ && dummy_inc == 2'd3) begin
						dummy_cnt_d = '0;
						emit        = 1'b1;
						emit_kind   = sshp_pkg::KIND_READ;
					end else begin
						dummy_cnt_d = dummy_inc;
					end
				end
				sshp_pkg::PH_ATCMD: begin
					at_we      = 1'b1;
					byte_cnt_d = byte_cnt_q + 2'd1;
					if (byte_cnt_q == 2'd3) begin
						emit      = 1'b1;
						emit_kind = sshp_pkg::KIND_AT;
						emit_word = {head.rx_byte, at_q[2], at_q[1], at_q[0]};
					end
				end
				sshp_pkg::PH_HOLD: begin
				end
				default: begin
				end
			endcase
			if (emit)
				phase_d = sshp_pkg::PH_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= sshp_pkg::PH_COMMAND;
			req_kind_q  <= sshp_pkg::KIND_WRITE;
			byte_cnt_q  <= '0;
			dummy_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_d;
				req_kind_q  <= req_kind_d;
				byte_cnt_q  <= byte_cnt_d;
				dummy_cnt_q <= dummy_cnt_d;
			end
			if (pop && emit)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && len_low_we)
			len_low_q <= head.rx_byte;
		if (pop && decl_len_we)
			decl_len_q <= len_new;
		if (pop && at_we)
			at_q[at_idx] <= head.rx_byte;
		if (pop && emit) begin
			out_kind_q <= emit_kind;
			out_len_q  <= emit_len;
			out_word_q <= emit_word;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.frame_kind   = out_kind_q;
	assign rsp.frame_length = out_len_q;
	assign rsp.atcmd_word   = out_word_q;

endmodule

// File: rtl/core/spi_slave_command_header_parser.sv
// ----------------------------------------------------------------------------
// spi_slave_command_header_parser
// SPI slave request header parser with APB register bank.
//
// req carries one word per received SPI byte (cmd 0) or a release (cmd 1).
// rsp carries one result per completed header or NACK: frame kind, write
// length and the four AT command bytes.
// A word accepted on req is classified and written into a two-entry queue;
// the header state machine takes one queued word per cycle when the result
// register is free or being emptied. The word that completes the frame is
// queued, then taken by the state machine, whose step loads the result
// register. Sustained rate is one word per cycle while rsp does not stall.
// When rsp stalls, the result register holds, the queue fills and req.ready
// falls once both entries are taken; nothing is dropped.
// Reset clears the queue, the result register and returns the parser to
// command state; registers take their defaults. After a result, bytes are
// ignored until a release word arrives.
// ----------------------------------------------------------------------------
module spi_slave_command_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	sshp_in_if.sink     req,
	sshp_out_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	sshp_pkg::cfg_t    cfg_q;
	sshp_pkg::reg_idx_t reg_idx;
	logic              cfg_we;
	logic              q_full, q_not_empty, push, pop;
	sshp_pkg::item_t   push_item, head;

	assign pready  = 1'b1;
	assign reg_idx = sshp_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_we  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.write_opcode <= sshp_pkg::WRITE_OPCODE_RST;
			cfg_q.read_opcode  <= sshp_pkg::READ_OPCODE_RST;
			cfg_q.dummy_value  <= sshp_pkg::DUMMY_VALUE_RST;
			cfg_q.max_length   <= sshp_pkg::MAX_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (reg_idx)
				sshp_pkg::REG_WRITE_OPCODE: cfg_q.write_opcode <= pwdata[7:0];
				sshp_pkg::REG_READ_OPCODE:  cfg_q.read_opcode  <= pwdata[7:0];
				sshp_pkg::REG_DUMMY_VALUE:  cfg_q.dummy_value  <= pwdata[7:0];
				sshp_pkg::REG_MAX_LENGTH:   cfg_q.max_length   <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			sshp_pkg::REG_WRITE_OPCODE: prdata = {24'd0, cfg_q.write_opcode};
			sshp_pkg::REG_READ_OPCODE:  prdata = {24'd0, cfg_q.read_opcode};
			sshp_pkg::REG_DUMMY_VALUE:  prdata = {24'd0, cfg_q.dummy_value};
			sshp_pkg::REG_MAX_LENGTH:   prdata = {16'd0, cfg_q.max_length};
			default:                    prdata = '0;
		endcase
	end

	sshp_front u_front (
		.req    (req),
		.cfg    (cfg_q),
		.q_full (q_full),
		.push   (push),
		.item   (push_item)
	);

	sshp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	sshp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.max_length  (cfg_q.max_length),
		.q_not_empty (q_not_empty),
		.head        (head),
		.pop         (pop),
		.rsp         (rsp)
	);

endmodule
